[sv/rtp_jitter_reorder_nack_top_assert.svh]
// assertion macros for the reorder buffer checker
`ifndef RTP_JITTER_REORDER_NACK_TOP_ASSERT_SVH
`define RTP_JITTER_REORDER_NACK_TOP_ASSERT_SVH

// a stalled word keeps valid high and its contents unchanged
`define RJRN_ASSERT_HOLD(lbl, v, r, d) \
  lbl: assert property (@(posedge clk) disable iff (rst) (v && !r) |=> (v && $stable(d))) \
    else $error("stalled word changed");

// a condition that must hold in the same cycle
`define RJRN_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("implication failed");

`endif

[sv/rjrn_pkg.sv]
// shared types and constants of the reorder buffer
package rjrn_pkg;

  // ring depth must be a power of two
  localparam int RING_DEPTH  = 32;
  localparam int RING_W      = $clog2(RING_DEPTH);
  localparam int GROUP_STEP  = 17;
  localparam int OFS_W       = $clog2(RING_DEPTH + GROUP_STEP) + 1;
  localparam int SEQ_W       = 32;
  localparam int TIME_W      = 63;
  localparam int NS_W        = 30;
  localparam int CFG_W       = 20;
  localparam int IDX_W       = 2;
  localparam int BLP_BITS    = 16;
  localparam int DUP_WINDOW  = 32;
  localparam int MIN_LEN     = 12;
  localparam int NS_PER_US   = 1000;
  localparam int DWELL_RESET = 30000;
  localparam int NACK_RESET  = 50000;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    KIND_EMIT = 3'd0,
    KIND_NACK = 3'd1,
    KIND_LOSS = 3'd2,
    KIND_DUP  = 3'd3,
    KIND_LATE = 3'd4
  } kind_t;

  typedef enum logic {
    CMD_PACKET = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  typedef enum logic [IDX_W-1:0] {
    REG_DWELL = 2'd0,
    REG_NACK  = 2'd1
  } reg_idx_t;

  typedef struct packed {
    cmd_t        command;
    logic [15:0] seq_number;
    logic [15:0] packet_length;
    logic [15:0] packet_handle;
    logic [62:0] time_ns;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] out_seq;
    logic [15:0] nack_mask;
    logic [15:0] loss_count;
    logic [15:0] out_handle;
    logic        last;
  } res_t;

  // queued work between front and back
  typedef struct packed {
    cmd_t        command;
    logic [15:0] seq;
    logic [15:0] handle;
    logic [62:0] now;
  } qent_t;

endpackage

[sv/rjrn_front.sv]
// front end: accepts words, drops short packets, queues the rest
module rjrn_front import rjrn_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  item_t item,
  output logic  q_valid,
  input  logic  q_ready,
  output qent_t q_data
);

  localparam int QP_W = $clog2(QUEUE_DEPTH);

  qent_t             slots [QUEUE_DEPTH];
  logic [QP_W-1:0]   wr_ptr;
  logic [QP_W-1:0]   rd_ptr;
  logic [QP_W:0]     count;
  logic              keep;
  logic              push;
  logic              pop;

  // short packets leave no trace
  assign keep = (item.command == CMD_TICK) || (item.packet_length >= 16'(MIN_LEN));
  assign item_ready = (count < (QP_W+1)'(QUEUE_DEPTH));
  assign push = item_valid && item_ready && keep;
  assign q_valid = (count != '0);
  assign pop = q_valid && q_ready;
  assign q_data = slots[rd_ptr];

  // queue pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QP_W+1)'(push) - (QP_W+1)'(pop);
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{command: item.command, seq: item.seq_number,
                         handle: item.packet_handle, now: item.time_ns};
    end
  end

endmodule

[sv/rjrn_back.sv]
// back end: ring state, drain, nack scan, dwell sweep and result stage
module rjrn_back import rjrn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  qent_t            q_data,
  input  logic             cfg_valid,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             result_valid,
  input  logic             result_ready,
  output res_t             result
);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_EXT     = 11'b000_0000_0010,
    ST_CLASS   = 11'b000_0000_0100,
    ST_STORE   = 11'b000_0000_1000,
    ST_DRAIN   = 11'b000_0001_0000,
    ST_NK_INIT = 11'b000_0010_0000,
    ST_NK_SCAN = 11'b000_0100_0000,
    ST_SW_HEAD = 11'b000_1000_0000,
    ST_SW_MIN  = 11'b001_0000_0000,
    ST_SW_DEC  = 11'b010_0000_0000,
    ST_DONE    = 11'b100_0000_0000
  } state_t;

  state_t              state, state_next;
  logic                started, started_next;
  logic [SEQ_W-1:0]    ne, ne_next;
  logic [SEQ_W-1:0]    hs, hs_next;
  logic [RING_DEPTH-1:0] full, full_next;
  logic [RING_DEPTH-1:0] nacked, nacked_next;
  qent_t               cur, cur_next;
  logic                tick, tick_next;
  logic                in_sweep, in_sweep_next;
  logic [SEQ_W-1:0]    ext, ext_next;
  logic [RING_W-1:0]   span, span_next;
  logic [OFS_W-1:0]    ofs, ofs_next;
  logic                found, found_next;
  logic [TIME_W-1:0]   earliest, earliest_next;
  logic [NS_W-1:0]     dwell_lim_ns;
  logic [NS_W-1:0]     ival_ns;

  logic [TIME_W-1:0]   arr_mem    [RING_DEPTH];
  logic [TIME_W-1:0]   nt_mem     [RING_DEPTH];
  logic [15:0]         handle_mem [RING_DEPTH];

  res_t                pend;
  logic                pend_valid;
  logic                out_free;
  logic                emit_req;
  res_t                emit_res;
  logic                go;
  logic                store_we;
  logic                nt_we;

  logic [RING_W-1:0]   head;
  logic [SEQ_W-1:0]    win;
  logic [RING_W-1:0]   span_calc;
  logic [15:0]         seq_delta;
  logic [SEQ_W-1:0]    ahead;
  logic [SEQ_W-1:0]    behind;
  logic [SEQ_W-1:0]    skip;
  logic [RING_DEPTH-1:0] clr_mask;
  logic [RING_W-1:0]   off;
  logic [RING_W-1:0]   si;
  logic [RING_W-1:0]   pi;
  logic [OFS_W-1:0]    bo;
  logic [RING_W-1:0]   bi;
  logic [BLP_BITS-1:0] blp;
  logic                nack_due;
  logic                expired;
  logic [SEQ_W-1:0]    pid;

  // window bookkeeping
  assign head      = ne[RING_W-1:0];
  assign win       = hs - ne;
  assign span_calc = (win >= SEQ_W'(RING_DEPTH)) ? RING_W'(RING_DEPTH - 1) : win[RING_W-1:0];
  assign seq_delta = cur.seq - hs[15:0];
  assign ahead     = ext - ne;
  assign behind    = ne - ext;
  assign skip      = ahead - SEQ_W'(RING_DEPTH - 1);
  assign si        = ext[RING_W-1:0];
  assign pi        = head + ofs[RING_W-1:0];
  assign pid       = ne + SEQ_W'(ofs);
  assign out_free  = !result_valid || result_ready;
  assign go        = !(emit_req && pend_valid && !out_free);
  assign q_ready   = (state == ST_IDLE);

  // slots freed by an overflow skip
  always_comb begin
    off = '0;
    for (int j = 0; j < RING_DEPTH; j++) begin
      off = RING_W'(j) - head;
      clr_mask[j] = (|skip[SEQ_W-1:RING_W]) || (off < skip[RING_W-1:0]);
    end
  end

  // loss bitmap following the nack pid
  always_comb begin
    bo = '0;
    bi = '0;
    for (int b = 0; b < BLP_BITS; b++) begin
      bo = ofs + OFS_W'(b + 1);
      bi = head + bo[RING_W-1:0];
      blp[b] = (bo <= OFS_W'(span)) && !full[bi];
    end
  end

  // timer checks
  assign nack_due = !nacked[pi] ||
                    ((cur.now >= nt_mem[pi]) &&
                     ((cur.now - nt_mem[pi]) >= TIME_W'(ival_ns)));
  assign expired  = found && (cur.now >= earliest) &&
                    ((cur.now - earliest) >= TIME_W'(dwell_lim_ns));

  // sequencer
  always_comb begin
    state_next    = state;
    started_next  = started;
    ne_next       = ne;
    hs_next       = hs;
    full_next     = full;
    nacked_next   = nacked;
    cur_next      = cur;
    tick_next     = tick;
    in_sweep_next = in_sweep;
    ext_next      = ext;
    span_next     = span;
    ofs_next      = ofs;
    found_next    = found;
    earliest_next = earliest;
    emit_req      = 1'b0;
    emit_res      = '0;
    store_we      = 1'b0;
    nt_we         = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          cur_next   = q_data;
          tick_next  = (q_data.command == CMD_TICK);
          state_next = (q_data.command == CMD_TICK) ? ST_SW_HEAD : ST_EXT;
        end
      end
      ST_EXT: begin
        if (!started) begin
          emit_req            = 1'b1;
          emit_res.kind       = KIND_EMIT;
          emit_res.out_seq    = cur.seq;
          emit_res.out_handle = cur.handle;
          started_next        = 1'b1;
          ne_next             = SEQ_W'(cur.seq) + 1'b1;
          hs_next             = SEQ_W'(cur.seq);
          state_next          = ST_DONE;
        end else begin
          ext_next   = hs + {{(SEQ_W-16){seq_delta[15]}}, seq_delta};
          state_next = ST_CLASS;
        end
      end
      ST_CLASS: begin
        if (ext < ne) begin
          emit_req            = 1'b1;
          emit_res.kind       = (behind <= SEQ_W'(DUP_WINDOW)) ? KIND_DUP : KIND_LATE;
          emit_res.out_seq    = cur.seq;
          emit_res.out_handle = cur.handle;
          state_next          = ST_DONE;
        end else if (ahead >= SEQ_W'(RING_DEPTH)) begin
          emit_req            = 1'b1;
          emit_res.kind       = KIND_LOSS;
          emit_res.out_seq    = ne[15:0];
          emit_res.loss_count = (|skip[SEQ_W-1:16]) ? 16'hFFFF : skip[15:0];
          full_next           = full & ~clr_mask;
          nacked_next         = nacked & ~clr_mask;
          ne_next             = ne + skip;
          state_next          = ST_STORE;
        end else begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        if (full[si]) begin
          emit_req            = 1'b1;
          emit_res.kind       = KIND_DUP;
          emit_res.out_seq    = cur.seq;
          emit_res.out_handle = cur.handle;
          state_next          = ST_DONE;
        end else begin
          full_next[si]   = 1'b1;
          nacked_next[si] = 1'b0;
          store_we        = 1'b1;
          if (!(ext < hs)) hs_next = ext;
          in_sweep_next   = 1'b0;
          state_next      = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (full[head]) begin
          emit_req            = 1'b1;
          emit_res.kind       = KIND_EMIT;
          emit_res.out_seq    = ne[15:0];
          emit_res.out_handle = handle_mem[head];
          full_next[head]     = 1'b0;
          nacked_next[head]   = 1'b0;
          ne_next             = ne + 1'b1;
        end else begin
          state_next = in_sweep ? ST_SW_HEAD : ST_NK_INIT;
        end
      end
      ST_NK_INIT: begin
        if (ne >= hs) begin
          state_next = tick ? ST_DONE : ST_SW_HEAD;
        end else begin
          span_next  = span_calc;
          ofs_next   = '0;
          state_next = ST_NK_SCAN;
        end
      end
      ST_NK_SCAN: begin
        if (ofs > OFS_W'(span)) begin
          state_next = tick ? ST_DONE : ST_SW_HEAD;
        end else if (full[pi]) begin
          ofs_next = ofs + 1'b1;
        end else begin
          if (nack_due) begin
            emit_req           = 1'b1;
            emit_res.kind      = KIND_NACK;
            emit_res.out_seq   = pid[15:0];
            emit_res.nack_mask = blp;
            nacked_next[pi]    = 1'b1;
            nt_we              = 1'b1;
          end
          ofs_next = ofs + OFS_W'(GROUP_STEP);
        end
      end
      ST_SW_HEAD: begin
        in_sweep_next = 1'b1;
        if (!(ne <= hs) || full[head]) begin
          state_next = tick ? ST_NK_INIT : ST_DONE;
        end else begin
          span_next  = span_calc;
          ofs_next   = OFS_W'(1);
          found_next = 1'b0;
          state_next = ST_SW_MIN;
        end
      end
      ST_SW_MIN: begin
        if (ofs > OFS_W'(span)) begin
          state_next = ST_SW_DEC;
        end else begin
          if (full[pi] && (!found || (arr_mem[pi] < earliest))) begin
            earliest_next = arr_mem[pi];
            found_next    = 1'b1;
          end
          ofs_next = ofs + 1'b1;
        end
      end
      ST_SW_DEC: begin
        if (expired) begin
          emit_req            = 1'b1;
          emit_res.kind       = KIND_LOSS;
          emit_res.out_seq    = ne[15:0];
          emit_res.loss_count = 16'd1;
          nacked_next[head]   = 1'b0;
          ne_next             = ne + 1'b1;
          in_sweep_next       = 1'b1;
          state_next          = ST_DRAIN;
        end else begin
          state_next = tick ? ST_NK_INIT : ST_DONE;
        end
      end
      ST_DONE: begin
        if (!pend_valid || out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      started <= 1'b0;
      ne      <= '0;
      hs      <= '0;
      full    <= '0;
      nacked  <= '0;
      tick    <= 1'b0;
      found   <= 1'b0;
      in_sweep <= 1'b0;
    end else if (go) begin
      state    <= state_next;
      started  <= started_next;
      ne       <= ne_next;
      hs       <= hs_next;
      full     <= full_next;
      nacked   <= nacked_next;
      tick     <= tick_next;
      found    <= found_next;
      in_sweep <= in_sweep_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (go) begin
      cur      <= cur_next;
      ext      <= ext_next;
      span     <= span_next;
      ofs      <= ofs_next;
      earliest <= earliest_next;
    end
  end

  // per-slot storage
  always_ff @(posedge clk) begin
    if (store_we) begin
      arr_mem[si]    <= cur.now;
      handle_mem[si] <= cur.handle;
    end
    if (nt_we && go) nt_mem[pi] <= cur.now;
  end

  // configuration, kept as nanoseconds
  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_lim_ns <= NS_W'(DWELL_RESET * NS_PER_US);
      ival_ns      <= NS_W'(NACK_RESET * NS_PER_US);
    end else if (cfg_valid && (cfg_data != '0)) begin
      if (cfg_index == REG_DWELL) dwell_lim_ns <= NS_W'({10'd0, cfg_data} * NS_W'(NS_PER_US));
      if (cfg_index == REG_NACK) ival_ns <= NS_W'({10'd0, cfg_data} * NS_W'(NS_PER_US));
    end
  end

  // result held back one step so the final one can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) result_valid <= 1'b0;
      if (go && emit_req) begin
        if (pend_valid) result_valid <= 1'b1;
        pend_valid <= 1'b1;
      end
      if ((state == ST_DONE) && pend_valid && out_free) begin
        result_valid <= 1'b1;
        pend_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit_req) begin
      if (pend_valid) result <= pend;
      pend <= emit_res;
    end
    if ((state == ST_DONE) && pend_valid && out_free) begin
      result      <= pend;
      result.last <= 1'b1;
    end
  end

endmodule

[sv/rtp_jitter_reorder_nack_top.sv]
// top level of the rtp reorder buffer with nack generation
// Usage:
// - item channel (item_valid/item_ready/item): one word per packet arrival
//   or time tick; packets shorter than 12 bytes are consumed with no result.
// - result channel (result_valid/result_ready/result): emit, nack, loss and
//   drop words in order; the final word caused by an input has last set.
// - cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): write dwell limit
//   (index 0) or nack interval (index 1) in microseconds, only while idle;
//   a zero write is ignored. cfg_ready is always high.
// Flow: a two-word queue accepts input while the back end works; the back end
// takes the next item only from idle, once the last one is through. Each item
// passes through extension, classification, store, drain, nack scan and dwell
// sweep steps as needed; each dwell skip repeats the drain and the sweep.
// A word is held back in a pending register so the final one can carry last.
// Reset: synchronous; empties the ring and the queue and restores the
// register defaults (30000 us and 50000 us). No clearing pass is needed.
// Stall: when result_ready is low the sequencer holds at its next result
// and the queue fills, after which item_ready drops.
module rtp_jitter_reorder_nack_top import rjrn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  item_t            item,
  output logic             result_valid,
  input  logic             result_ready,
  output res_t             result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic  q_valid;
  logic  q_ready;
  qent_t q_data;

  assign cfg_ready = 1'b1;

  // accept and filter
  rjrn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_data     (q_data)
  );

  // ring processing
  rjrn_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_data       (q_data),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

[sv/rjrn_checker.sv]
// port checker for the reorder buffer, bound to the top level
`include "rtp_jitter_reorder_nack_top_assert.svh"

module rjrn_checker import rjrn_pkg::*; (
  input logic clk,
  input logic rst,
  input logic result_valid,
  input logic result_ready,
  input res_t result
);

  logic nack_word;
  logic emit_word;

  // word kind decode
  assign nack_word = result_valid && (result.kind == KIND_NACK);
  assign emit_word = result_valid && (result.kind == KIND_EMIT);

  // stalled result holds
  `RJRN_ASSERT_HOLD(a_res_hold, result_valid, result_ready, result)
  // nack words carry no handle and no count
  `RJRN_ASSERT_IMPL(a_nack_fields, nack_word, (result.out_handle == '0) && (result.loss_count == '0))
  // emit words carry no mask and no count
  `RJRN_ASSERT_IMPL(a_emit_fields, emit_word, (result.nack_mask == '0) && (result.loss_count == '0))
  // nothing is shown right after reset
  `RJRN_ASSERT_IMPL(a_reset_quiet, $past(rst), !result_valid)

endmodule

bind rtp_jitter_reorder_nack_top rjrn_checker u_chk (.*);
